// ----- rtl/adsr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared types, codes and constants of the ADSR envelope generator.
// ----------------------------------------------------------------------------
package adsr_pkg;

  localparam int FRAC_BITS_DEF = 24;
  localparam int CFG_IDX_W     = 2;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } adsr_phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK_RATE   = 2'd0,
    CFG_DECAY_RATE    = 2'd1,
    CFG_SUSTAIN_LEVEL = 2'd2,
    CFG_RELEASE_RATE  = 2'd3
  } adsr_cfg_idx_t;

  typedef struct packed {
    adsr_phase_t phase;
    logic        prev_gate;
    logic        prev_retrig;
  } adsr_ctl_t;

  // reset values, Q.24
  localparam logic [63:0] ATTACK_RATE_Q24   = 64'd34953;
  localparam logic [63:0] DECAY_RATE_Q24    = 64'd1748;
  localparam logic [63:0] SUSTAIN_LEVEL_Q24 = 64'd6710886;
  localparam logic [63:0] RELEASE_RATE_Q24  = 64'd1165;

  // rescale a Q.24 constant to Q.f
  function automatic logic [63:0] scale_q24(input logic [63:0] v, input int f);
    logic [63:0] res;
    if (f >= 24) begin
      res = v << (f - 24);
    end else begin
      res = v >> (24 - f);
    end
    return res;
  endfunction

endpackage

// ----- rtl/adsr_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_if
// Valid/ready channels: sample ticks in, envelope levels out.
// ----------------------------------------------------------------------------
interface adsr_in_if;
  logic valid;
  logic ready;
  logic gate;
  logic retrigger;

  modport source (output valid, output gate, output retrigger, input ready);
  modport sink   (input valid, input gate, input retrigger, output ready);
endinterface

interface adsr_out_if #(
  parameter int W = 25
);
  logic         valid;
  logic         ready;
  logic [W-1:0] env_level;
  logic [W-1:0] inv_level;

  modport source (output valid, output env_level, output inv_level, input ready);
  modport sink   (input valid, input env_level, input inv_level, output ready);
endinterface

// ----- rtl/adsr_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_cfg
// Coefficient registers; writes saturate to 1.0.
// ----------------------------------------------------------------------------
module adsr_cfg #(
  parameter int FRAC_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [adsr_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [FRAC_BITS:0]             cfg_data,
  output logic [FRAC_BITS:0]             atk_rate,
  output logic [FRAC_BITS:0]             dec_rate,
  output logic [FRAC_BITS:0]             sus_level,
  output logic [FRAC_BITS:0]             rel_rate
);
  import adsr_pkg::*;

  localparam int W = FRAC_BITS + 1;
  localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [W-1:0] atk_r, dec_r, sus_r, rel_r;
  logic [W-1:0] wdata;

  assign wdata = (cfg_data > ONE) ? ONE : cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atk_r <= W'(scale_q24(ATTACK_RATE_Q24, FRAC_BITS));
      dec_r <= W'(scale_q24(DECAY_RATE_Q24, FRAC_BITS));
      sus_r <= W'(scale_q24(SUSTAIN_LEVEL_Q24, FRAC_BITS));
      rel_r <= W'(scale_q24(RELEASE_RATE_Q24, FRAC_BITS));
    end else if (cfg_we) begin
      case (adsr_cfg_idx_t'(cfg_idx))
        CFG_ATTACK_RATE:   atk_r <= wdata;
        CFG_DECAY_RATE:    dec_r <= wdata;
        CFG_SUSTAIN_LEVEL: sus_r <= wdata;
        CFG_RELEASE_RATE:  rel_r <= wdata;
        default: ;
      endcase
    end
  end

  assign atk_rate  = atk_r;
  assign dec_rate  = dec_r;
  assign sus_level = sus_r;
  assign rel_rate  = rel_r;

endmodule

// ----- rtl/adsr_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_step
// One envelope update: edge detect, phase select, shared multiply.
// ----------------------------------------------------------------------------
module adsr_step #(
  parameter int FRAC_BITS = 24
) (
  input  adsr_pkg::adsr_ctl_t ctl_cur,
  input  logic                gate,
  input  logic                retrig,
  input  logic [FRAC_BITS:0]  env_cur,
  input  logic [FRAC_BITS:0]  atk_rate,
  input  logic [FRAC_BITS:0]  dec_rate,
  input  logic [FRAC_BITS:0]  sus_level,
  input  logic [FRAC_BITS:0]  rel_rate,
  output adsr_pkg::adsr_ctl_t ctl_nxt,
  output logic [FRAC_BITS:0]  env_nxt,
  output logic [FRAC_BITS:0]  inv_nxt
);
  import adsr_pkg::*;

  localparam int W = FRAC_BITS + 1;
  localparam logic [63:0]  ONE64 = 64'(1) << FRAC_BITS;
  localparam logic [W-1:0] ONE   = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [W-1:0] ATK_TARGET = W'((ONE64 * 64'd6) / 64'd5);
  localparam logic [W-1:0] DECAY_BAND = W'(ONE64 / 64'd1000);
  localparam logic [W-1:0] REL_FLOOR  = W'(ONE64 / 64'd10000);

  adsr_phase_t    ph;
  logic [W-1:0]   lv;
  logic [W-1:0]   mul_a, mul_b;
  logic [2*W-1:0] prod;
  logic [W-1:0]   mq;
  logic [W-1:0]   lv_sub;
  logic [W-1:0]   lv_add;
  logic [W:0]     sus_band;

  always_comb begin
    ph = ctl_cur.phase;
    if (gate && !ctl_cur.prev_gate) begin
      ph = PH_ATTACK;
    end else if (!gate && ctl_cur.prev_gate) begin
      ph = PH_RELEASE;
    end
    if (retrig && !ctl_cur.prev_retrig) begin
      ph = PH_ATTACK;
    end
  end

  assign lv = (env_cur > ONE) ? ONE : env_cur;

  always_comb begin
    case (ph)
      PH_ATTACK: begin
        mul_a = atk_rate;
        mul_b = ATK_TARGET - lv;
      end
      PH_DECAY: begin
        mul_a = dec_rate;
        mul_b = lv - sus_level;
      end
      PH_RELEASE: begin
        mul_a = rel_rate;
        mul_b = lv;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod     = {{W{1'b0}}, mul_a} * {{W{1'b0}}, mul_b};
  assign mq       = prod[FRAC_BITS +: W];
  assign lv_sub   = lv - mq;
  assign lv_add   = lv + mq;
  assign sus_band = {1'b0, sus_level} + {1'b0, DECAY_BAND};

  always_comb begin
    ctl_nxt.phase       = ph;
    ctl_nxt.prev_gate   = gate;
    ctl_nxt.prev_retrig = retrig;
    env_nxt             = '0;
    case (ph)
      PH_ATTACK: begin
        if (lv_add >= ONE) begin
          env_nxt       = ONE;
          ctl_nxt.phase = PH_DECAY;
        end else begin
          env_nxt = lv_add;
        end
      end
      PH_DECAY: begin
        if (lv <= sus_level || {1'b0, lv_sub} <= sus_band) begin
          env_nxt       = sus_level;
          ctl_nxt.phase = PH_SUSTAIN;
        end else begin
          env_nxt = lv_sub;
        end
      end
      PH_SUSTAIN: begin
        env_nxt = sus_level;
      end
      PH_RELEASE: begin
        if (lv_sub <= REL_FLOOR) begin
          env_nxt       = '0;
          ctl_nxt.phase = PH_IDLE;
        end else begin
          env_nxt = lv_sub;
        end
      end
      default: begin
        env_nxt = '0;
      end
    endcase
  end

  assign inv_nxt = ONE - env_nxt;

endmodule

// ----- rtl/adsr_envelope_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_envelope_generator
// ADSR envelope generator, one level per audio sample tick.
// ----------------------------------------------------------------------------
// Takes one sample-tick request per cycle unless the output side stalls and
// returns one level request per tick, via the s1 register and then the
// output register. Throughput is one tick per clock when not stalled: the
// envelope state feeds back through a single combinational update path (one
// FRAC_BITS+1 square multiply shared by attack, decay and release). Levels are
// unsigned Q.FRAC_BITS, 1.0 = 2^FRAC_BITS. Coefficient registers are written
// through cfg_* and saturate to 1.0; write them only while no tick is in flight.
module adsr_envelope_generator #(
  parameter int FRAC_BITS = adsr_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  adsr_in_if.sink                        in_bus,
  adsr_out_if.source                     out_bus,
  input  logic                           cfg_we,
  input  logic [adsr_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [FRAC_BITS:0]             cfg_data
);
  import adsr_pkg::*;

  localparam int W = FRAC_BITS + 1;
  localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [W-1:0] atk_rate, dec_rate, sus_level, rel_rate;

  logic         s1_vld_r;
  logic         s1_gate_r;
  logic         s1_retrig_r;
  adsr_ctl_t    ctl_r;
  logic [W-1:0] env_r;
  logic         out_vld_r;
  logic [W-1:0] out_env_r;
  logic [W-1:0] out_inv_r;

  adsr_ctl_t    ctl_nxt;
  logic [W-1:0] env_nxt;
  logic [W-1:0] inv_nxt;
  logic         s1_adv;
  logic         in_acc;

  adsr_cfg #(
    .FRAC_BITS(FRAC_BITS)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .atk_rate (atk_rate),
    .dec_rate (dec_rate),
    .sus_level(sus_level),
    .rel_rate (rel_rate)
  );

  adsr_step #(
    .FRAC_BITS(FRAC_BITS)
  ) u_step (
    .ctl_cur  (ctl_r),
    .gate     (s1_gate_r),
    .retrig   (s1_retrig_r),
    .env_cur  (env_r),
    .atk_rate (atk_rate),
    .dec_rate (dec_rate),
    .sus_level(sus_level),
    .rel_rate (rel_rate),
    .ctl_nxt  (ctl_nxt),
    .env_nxt  (env_nxt),
    .inv_nxt  (inv_nxt)
  );

  assign s1_adv       = s1_vld_r && (!out_vld_r || out_bus.ready);
  assign in_bus.ready = !s1_vld_r || s1_adv;
  assign in_acc       = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      ctl_r     <= '{phase: PH_IDLE, prev_gate: 1'b0, prev_retrig: 1'b0};
      env_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_bus.ready) begin
        s1_vld_r <= in_bus.valid;
      end
      if (s1_adv) begin
        ctl_r     <= ctl_nxt;
        env_r     <= env_nxt;
        out_vld_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_gate_r   <= in_bus.gate;
      s1_retrig_r <= in_bus.retrigger;
    end
    if (s1_adv) begin
      out_env_r <= env_nxt;
      out_inv_r <= inv_nxt;
    end
  end

  assign out_bus.valid     = out_vld_r;
  assign out_bus.env_level = out_env_r;
  assign out_bus.inv_level = out_inv_r;

  a_env_range: assert property (@(posedge clk) disable iff (!rst_n)
    env_r <= ONE)
    else $error("envelope level above 1.0");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.phase == PH_IDLE |-> env_r == '0)
    else $error("idle phase with nonzero level");

  a_out_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> W'(out_env_r + out_inv_r) == ONE)
    else $error("level and inverse do not sum to 1.0");

  a_adv_load: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_vld_r)
    else $error("advanced tick did not reach output register");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_bus.ready |=> $stable(env_r) && $stable(ctl_r))
    else $error("envelope state moved while output stalled");

endmodule
